// ===== src/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg: shared types and codes for the circular deque
// Command, status and cell operation codes, and the per-cell control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  localparam int unsigned DATA_W = 32;

  // command codes
  localparam logic [2:0] CMD_CREATE     = 3'd0;
  localparam logic [2:0] CMD_DISPLAY    = 3'd1;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd2;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd3;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd4;
  localparam logic [2:0] CMD_POP_BACK   = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // cell operations
  localparam logic [2:0] OP_HOLD      = 3'd0;
  localparam logic [2:0] OP_SHIFT_IN  = 3'd1;  // take from front-side neighbor
  localparam logic [2:0] OP_SHIFT_OUT = 3'd2;  // take from back-side neighbor
  localparam logic [2:0] OP_LOAD      = 3'd3;  // selected cell takes new value
  localparam logic [2:0] OP_ROTATE    = 3'd4;  // shift out, selected cell takes front

  typedef struct packed {
    logic [2:0] op;
    logic       hit;  // this cell is the selected position
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque: bounded double-ended queue of signed 32-bit values
//
// Input channel (in_valid / in_stall): one beat carries a command and
// value_in. Output channel (out_valid / out_stall): one beat per result with
// value_out, status and last; last marks the final result of a command.
//
// Storage is a chain of DEPTH cells ordered front (cell 0) to back. Push
// front shifts the chain toward the back, pop front shifts it toward the
// front, push back and create load one selected cell, pop back reads the
// tail cell. Display rotates the chain one cell per cycle while the output
// register is free, sending cell 0 out and putting it behind the tail, so
// after fill_count steps the order is back where it started.
//
// Timing: create, push and pop results land in the output register at the
// edge that takes the input beat, as does the empty status of a display on
// an empty queue; otherwise the first display value lands in the cycle
// after. Display first starts its stream and then shows its values in turn.
// Unused command codes produce no result. While display streams or while a
// result sits stalled in the output register, in_stall is high. Reset empties
// the queue and holds in_stall high; cell contents are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque import dq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               command,
  input  logic signed [DATA_W-1:0] value_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] value_out,
  output logic [1:0]               status,
  output logic                     last
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SHOW = 1'b1;

  logic              state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     left, left_next;   // display values still to send
  logic [CW-1:0]     cnt_dec;

  logic [DATA_W-1:0] cell_vals [DEPTH];
  logic [2:0]        cell_op;
  logic [IW-1:0]     sel;

  logic              out_free;
  logic              in_acc;
  logic              emit;
  logic [DATA_W-1:0] emit_val;
  logic [1:0]        emit_st;
  logic              emit_last;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = rst || !((state == S_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign cnt_dec  = count - 1'b1;

  // ---- cell chain ----
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t         ctl;
    logic [DATA_W-1:0] prev_v;
    logic [DATA_W-1:0] next_v;

    assign ctl.op  = cell_op;
    assign ctl.hit = (sel == IW'(i));

    if (i == 0) begin : g_head
      assign prev_v = value_in;
    end else begin : g_mid_p
      assign prev_v = cell_vals[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_v = cell_vals[i];
    end else begin : g_mid_n
      assign next_v = cell_vals[i+1];
    end

    dq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .value_in (value_in),
      .prev_val (prev_v),
      .next_val (next_v),
      .wrap_val (cell_vals[0]),
      .value    (cell_vals[i])
    );
  end

  // ---- command decode and display sequencing ----
  always_comb begin
    state_next = state;
    count_next = count;
    left_next  = left;
    cell_op    = OP_HOLD;
    sel        = '0;
    emit       = 1'b0;
    emit_val   = '0;
    emit_st    = ST_OK;
    emit_last  = 1'b1;

    if (state == S_IDLE) begin
      if (in_acc) begin
        unique case (command)
          CMD_CREATE: begin
            cell_op    = OP_LOAD;
            sel        = '0;
            count_next = CW'(1);
            emit       = 1'b1;
          end
          CMD_DISPLAY: begin
            if (count == '0) begin
              emit    = 1'b1;
              emit_st = ST_EMPTY;
            end else begin
              state_next = S_SHOW;
              left_next  = count;
            end
          end
          CMD_PUSH_FRONT: begin
            emit = 1'b1;
            if (count == CW'(DEPTH)) begin
              emit_st = ST_FULL;
            end else begin
              cell_op    = OP_SHIFT_IN;
              count_next = count + 1'b1;
            end
          end
          CMD_PUSH_BACK: begin
            emit = 1'b1;
            if (count == CW'(DEPTH)) begin
              emit_st = ST_FULL;
            end else begin
              cell_op    = OP_LOAD;
              sel        = count[IW-1:0];  // count < DEPTH here
              count_next = count + 1'b1;
            end
          end
          CMD_POP_FRONT: begin
            emit = 1'b1;
            if (count == '0) begin
              emit_st = ST_EMPTY;
            end else begin
              emit_val   = cell_vals[0];
              cell_op    = OP_SHIFT_OUT;
              count_next = cnt_dec;
            end
          end
          CMD_POP_BACK: begin
            emit = 1'b1;
            if (count == '0) begin
              emit_st = ST_EMPTY;
            end else begin
              emit_val   = cell_vals[cnt_dec[IW-1:0]];
              count_next = cnt_dec;
            end
          end
          default: begin
          end
        endcase
      end
    end else begin
      // stream front value, move it behind the tail
      if (out_free) begin
        emit      = 1'b1;
        emit_val  = cell_vals[0];
        emit_last = (left == CW'(1));
        cell_op   = OP_ROTATE;
        sel       = cnt_dec[IW-1:0];
        left_next = left - 1'b1;
        if (left == CW'(1)) state_next = S_IDLE;
      end
    end
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      left      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      left  <= left_next;
      if (out_free) out_valid <= emit;
    end
  end

  // ---- output payload ----
  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      value_out <= emit_val;
      status    <= emit_st;
      last      <= emit_last;
    end
  end

  // ---- checks ----
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above depth");

  a_show_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHOW) |-> (left != '0) && (left <= count))
    else $error("display counter out of range");

  a_create_one: assert property (@(posedge clk) disable iff (rst)
    (in_acc && command == CMD_CREATE) |=> (count == CW'(1)) && out_valid)
    else $error("create did not leave one element");

  a_show_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHOW && out_free && left == CW'(1)) |=> (state == S_IDLE) && last)
    else $error("display did not finish with last");

  a_no_accept_show: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHOW) |-> in_stall)
    else $error("input taken during display");

endmodule

`default_nettype wire

// ===== src/dq_cell.sv =====
// ----------------------------------------------------------------------------
// dq_cell: one storage cell of the deque chain
// Holds one value; loads, shifts from either neighbor or rotates per command.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_cell import dq_pkg::*; (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] value_in,
  input  logic [DATA_W-1:0] prev_val,
  input  logic [DATA_W-1:0] next_val,
  input  logic [DATA_W-1:0] wrap_val,
  output logic [DATA_W-1:0] value
);

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_SHIFT_IN:  value <= prev_val;
      OP_SHIFT_OUT: value <= next_val;
      OP_LOAD: begin
        if (ctl.hit) value <= value_in;
      end
      OP_ROTATE:    value <= ctl.hit ? wrap_val : next_val;
      default:      value <= value;
    endcase
  end

endmodule

`default_nettype wire
